// ----- sv/ksa_pkg.sv -----
// Shared constants and types for the key share scan accumulator.
`default_nettype none
package ksa_pkg;

   // key bytes gathered and canary bytes in a code match
   localparam int KEYS       = 8;
   localparam int CANARIES   = 4;
   localparam int WIN        = 2 + CANARIES + KEYS;
   localparam int FILL_W     = $clog2(WIN + 1);
   localparam int KEY_IDX_W  = (KEYS > 1) ? $clog2(KEYS) : 1;
   localparam int KEY_BYTES_W = 64;

   localparam logic [7:0] JMP_OPCODE = 8'hEB;
   localparam logic [7:0] LEN_MARK   = 8'((KEYS + CANARIES) & 255);

   // heap/stack period counter: gap + span, both 16 bit
   localparam int CNT_W = 16;
   localparam int POS_W = CNT_W + 1;

   // region codes on req_type
   localparam logic [1:0] REGION_CODE  = 2'd0;
   localparam logic [1:0] REGION_HEAP  = 2'd1;
   localparam logic [1:0] REGION_STACK = 2'd2;

   // register indexes
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_CANARY_BYTE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_GAP     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_USED    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STACK_GAP    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STACK_USED   = 3'd4;

   typedef struct packed {
      logic [7:0]       canary_byte;
      logic [CNT_W-1:0] heap_gap;
      logic [CNT_W-1:0] heap_used;
      logic [CNT_W-1:0] stack_gap;
      logic [CNT_W-1:0] stack_used;
   } ksa_cfg_type;

   // one processed byte as seen by a tracking unit
   typedef struct packed {
      logic       fire;     // byte is consumed this cycle
      logic       restart;  // byte opens a new region
      logic       active;   // byte belongs to this unit's region kind
      logic [7:0] data;
   } ksa_step_type;

endpackage
`default_nettype wire

// ----- sv/ksa_csr.sv -----
// Configuration registers of the key share scan accumulator.
`default_nettype none
module ksa_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_en,
   input  wire logic [ksa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [ksa_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output ksa_pkg::ksa_cfg_type                     cfg
);

   ksa_pkg::ksa_cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.canary_byte  <= 8'd0;
         cfg_ff.heap_gap     <= '0;
         cfg_ff.heap_used    <= ksa_pkg::CNT_W'(8);
         cfg_ff.stack_gap    <= '0;
         cfg_ff.stack_used   <= ksa_pkg::CNT_W'(8);
      end else if (csr_write_en) begin
         unique case (csr_index)
            ksa_pkg::CSR_CANARY_BYTE:  cfg_ff.canary_byte  <= csr_wdata[7:0];
            ksa_pkg::CSR_HEAP_GAP:     cfg_ff.heap_gap     <= csr_wdata;
            ksa_pkg::CSR_HEAP_USED:    cfg_ff.heap_used    <= csr_wdata;
            ksa_pkg::CSR_STACK_GAP:    cfg_ff.stack_gap    <= csr_wdata;
            ksa_pkg::CSR_STACK_USED:   cfg_ff.stack_used   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ----- sv/ksa_window.sv -----
// Code region sliding window and jump/canary pattern match.
`default_nettype none
module ksa_window (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire ksa_pkg::ksa_step_type                  step,
   input  wire logic [7:0]                             canary_byte,
   output logic                                        hit,
   output logic [ksa_pkg::KEYS-1:0][7:0]               share
);

   logic [ksa_pkg::WIN-1:0][7:0]    win_ff, win_in;
   logic [ksa_pkg::FILL_W-1:0]      fill_ff, fill_in, fill_base;
   logic                            canary_ok;

   always_comb begin
      // shift oldest out at index 0, newest in at the top
      for (int i = 0; i < ksa_pkg::WIN - 1; i++) begin
         win_in[i] = win_ff[i+1];
      end
      win_in[ksa_pkg::WIN-1] = step.data;

      fill_base = step.restart ? '0 : fill_ff;
      if (fill_base < ksa_pkg::FILL_W'(ksa_pkg::WIN)) begin
         fill_in = fill_base + 1'b1;
      end else begin
         fill_in = fill_base;
      end

      canary_ok = 1'b1;
      for (int i = 0; i < ksa_pkg::CANARIES; i++) begin
         if (win_in[2+i] != canary_byte) begin
            canary_ok = 1'b0;
         end
      end

      for (int i = 0; i < ksa_pkg::KEYS; i++) begin
         share[i] = win_in[2+ksa_pkg::CANARIES+i];
      end

      hit = step.fire && step.active
         && (fill_in == ksa_pkg::FILL_W'(ksa_pkg::WIN))
         && (win_in[0] == ksa_pkg::JMP_OPCODE)
         && (win_in[1] == ksa_pkg::LEN_MARK)
         && canary_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff  <= '0;
         fill_ff <= '0;
      end else if (step.fire) begin
         if (step.active) begin
            win_ff  <= win_in;
            fill_ff <= fill_in;
         end else if (step.restart) begin
            fill_ff <= '0;
         end
      end
   end

endmodule
`default_nettype wire

// ----- sv/ksa_period.sv -----
// Heap/stack period counter selecting which bytes are key shares.
`default_nettype none
module ksa_period (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire ksa_pkg::ksa_step_type               step,
   input  wire logic [ksa_pkg::CNT_W-1:0]           gap,
   input  wire logic [ksa_pkg::CNT_W-1:0]           used,
   output logic                                     share_en,
   output logic [ksa_pkg::KEY_IDX_W-1:0]            share_idx
);

   logic [ksa_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [ksa_pkg::POS_W-1:0] base, pos0, pos1, len, off;
   logic [ksa_pkg::CNT_W-1:0] span;

   always_comb begin
      // a short used span still covers a whole share
      span = (used < ksa_pkg::CNT_W'(ksa_pkg::KEYS)) ? ksa_pkg::CNT_W'(ksa_pkg::KEYS) : used;
      len  = {1'b0, gap} + {1'b0, span};
      base = step.restart ? '0 : pos_ff;
      // period shrank under us: restart it
      pos0 = (base >= len) ? '0 : base;
      off  = pos0 - {1'b0, gap};
      share_en = step.fire && step.active && (pos0 >= {1'b0, gap})
         && (off < ksa_pkg::POS_W'(ksa_pkg::KEYS));
      share_idx = off[ksa_pkg::KEY_IDX_W-1:0];
      pos1 = pos0 + 1'b1;
      pos_in = (pos1 >= len) ? '0 : pos1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (step.fire) begin
         if (step.active) begin
            pos_ff <= pos_in;
         end else if (step.restart) begin
            pos_ff <= '0;
         end
      end
   end

endmodule
`default_nettype wire

// ----- sv/key_share_scan_accumulator.sv -----
// Top level: input register, region trackers, key accumulators, result register.
//
//  channel | ports                                   | moves
//  --------+-----------------------------------------+--------------------------------
//  req     | req_valid/req_ready, req_type,          | one memory byte per transaction
//          | req_data_byte, req_last_in_region,      |
//          | req_last_of_scan                        |
//  rsp     | rsp_valid/rsp_ready, rsp_key_bytes      | packed keys, one per scan
//  csr     | csr_write_en, csr_index, csr_wdata      | register write, no handshake
//
// One byte per cycle sustained while nothing stalls. A byte is held in the input register and is
// folded into the window, period counter and keys as it leaves it; a scan's keys pass from the
// input register into the result register, which drives rsp.
// Reset (synchronous) clears windows, counters, keys and loads register defaults.
// Only a last-of-scan byte can stall, and only while the result register still
// holds an untaken transaction; req_ready then drops until rsp_ready frees it.
`default_nettype none
module key_share_scan_accumulator (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // byte stream
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [1:0]                           req_type,
   input  wire logic [7:0]                           req_data_byte,
   input  wire logic                                 req_last_in_region,
   input  wire logic                                 req_last_of_scan,
   // key result
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [ksa_pkg::KEY_BYTES_W-1:0]           rsp_key_bytes,
   // configuration
   input  wire logic                                 csr_write_en,
   input  wire logic [ksa_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [ksa_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   ksa_pkg::ksa_cfg_type cfg;

   // input register
   logic       in_valid_ff;
   logic [1:0] in_type_ff;
   logic [7:0] in_data_ff;
   logic       in_last_region_ff;
   logic       in_last_scan_ff;

   // region start flag: next processed byte opens a new region
   logic       start_ff, start_in;

   // result register
   logic                              out_valid_ff;
   logic [ksa_pkg::KEY_BYTES_W-1:0]   out_keys_ff;

   logic fire;
   logic is_heap;
   ksa_pkg::ksa_step_type code_step, per_step;

   logic                                 win_hit;
   logic [ksa_pkg::KEYS-1:0][7:0]        win_share;
   logic                                 per_en;
   logic [ksa_pkg::KEY_IDX_W-1:0]        per_idx;
   logic [ksa_pkg::CNT_W-1:0]            sel_gap, sel_used;

   logic [ksa_pkg::KEYS-1:0][7:0]        keys_ff, keys_in;
   logic [ksa_pkg::KEY_BYTES_W-1:0]      keys_packed;

   ksa_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   // a byte moves on unless it must drop keys into a still-full result register
   assign fire      = in_valid_ff && (!in_last_scan_ff || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;

   assign is_heap = (in_type_ff == ksa_pkg::REGION_HEAP);

   always_comb begin
      code_step.fire    = fire;
      code_step.restart = start_ff;
      code_step.active  = (in_type_ff == ksa_pkg::REGION_CODE);
      code_step.data    = in_data_ff;

      per_step.fire     = fire;
      per_step.restart  = start_ff;
      per_step.active   = is_heap || (in_type_ff == ksa_pkg::REGION_STACK);
      per_step.data     = in_data_ff;

      sel_gap  = is_heap ? cfg.heap_gap  : cfg.stack_gap;
      sel_used = is_heap ? cfg.heap_used : cfg.stack_used;
   end

   ksa_window u_window (
      .clock        (clock),
      .reset        (reset),
      .step         (code_step),
      .canary_byte  (cfg.canary_byte),
      .hit          (win_hit),
      .share        (win_share)
   );

   ksa_period u_period (
      .clock     (clock),
      .reset     (reset),
      .step      (per_step),
      .gap       (sel_gap),
      .used      (sel_used),
      .share_en  (per_en),
      .share_idx (per_idx)
   );

   // XOR gather; code and period shares never land in the same cycle
   always_comb begin
      keys_packed = '0;
      for (int k = 0; k < ksa_pkg::KEYS; k++) begin
         keys_in[k] = keys_ff[k];
         if (win_hit) begin
            keys_in[k] = keys_in[k] ^ win_share[k];
         end
         if (per_en && (per_idx == ksa_pkg::KEY_IDX_W'(k))) begin
            keys_in[k] = keys_in[k] ^ in_data_ff;
         end
         keys_packed[8*k +: 8] = keys_in[k];
      end
      start_in = in_last_region_ff || in_last_scan_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         start_ff     <= 1'b1;
         out_valid_ff <= 1'b0;
         keys_ff      <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (fire) begin
            start_ff <= start_in;
            if (in_last_scan_ff) begin
               keys_ff <= '0;
            end else begin
               keys_ff <= keys_in;
            end
         end
         if (fire && in_last_scan_ff) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_type_ff        <= req_type;
         in_data_ff        <= req_data_byte;
         in_last_region_ff <= req_last_in_region;
         in_last_scan_ff   <= req_last_of_scan;
      end
      if (fire && in_last_scan_ff) begin
         out_keys_ff <= keys_packed;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_key_bytes = out_keys_ff;

endmodule
`default_nettype wire
